// ===== hw/rtl/rpa_pkg.sv =====
// Shared types and constants for the radio packet auto-ack block.
// No dependencies; imported by every module of the block.
package rpa_pkg;

	localparam int ADDR_W    = 24;
	localparam int BYTE_W    = 8;
	localparam int POS_W     = 4;
	localparam int CFG_IDX_W = 1;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_AUTO_ACK_ADDR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THERMO_ADDR   = 1'b1;

	localparam logic [BYTE_W-1:0] TYPE_A      = 8'h30;
	localparam logic [BYTE_W-1:0] TYPE_SETTMP = 8'h40;
	localparam logic [BYTE_W-1:0] TYPE_C      = 8'h50;
	localparam logic [BYTE_W-1:0] THERMO_LEN  = 8'd11;
	localparam logic [BYTE_W-1:0] ACK_LEN     = 8'd11;
	localparam logic [BYTE_W-1:0] ACK_TYPE    = 8'd2;

	localparam logic [POS_W-1:0] POS_LEN     = 4'd0;
	localparam logic [POS_W-1:0] POS_CNT     = 4'd1;
	localparam logic [POS_W-1:0] POS_TYPE    = 4'd3;
	localparam logic [POS_W-1:0] POS_SRC0    = 4'd4;
	localparam logic [POS_W-1:0] POS_SRC1    = 4'd5;
	localparam logic [POS_W-1:0] POS_SRC2    = 4'd6;
	localparam logic [POS_W-1:0] POS_DST0    = 4'd7;
	localparam logic [POS_W-1:0] POS_DST1    = 4'd8;
	localparam logic [POS_W-1:0] POS_DST2    = 4'd9;
	localparam logic [POS_W-1:0] POS_MIN_END = 4'd9;
	localparam logic [POS_W-1:0] POS_MAX     = 4'd15;
	localparam logic [POS_W-1:0] ACK_LAST    = 4'd11;

	typedef struct packed {
		logic [BYTE_W-1:0] counter;
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic              rule_a;
		logic              rule_b;
	} ack_job_t;

endpackage

// ===== hw/rtl/rpa_front.sv =====
// Front end: captures header fields of received packets and decides on acks.
// Depends on rpa_pkg; pushes ack jobs into rpa_queue.
module rpa_front import rpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 end_of_packet,
	input  logic                 q_full,
	output logic                 q_push,
	output ack_job_t             q_data
);

	logic [ADDR_W-1:0] auto_addr_q, thermo_addr_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] len_q, cnt_q, type_q;
	logic [ADDR_W-1:0] src_q, dst_q;

	logic [BYTE_W-1:0] len_d, cnt_d, type_d;
	logic [ADDR_W-1:0] src_d, dst_d;
	logic              accept, rule_a, rule_b;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		len_d  = len_q;
		cnt_d  = cnt_q;
		type_d = type_q;
		src_d  = src_q;
		dst_d  = dst_q;
		case (pos_q)
			POS_LEN:  len_d  = rx_byte;
			POS_CNT:  cnt_d  = rx_byte;
			POS_TYPE: type_d = rx_byte;
			POS_SRC0: src_d[23:16] = rx_byte;
			POS_SRC1: src_d[15:8]  = rx_byte;
			POS_SRC2: src_d[7:0]   = rx_byte;
			POS_DST0: dst_d[23:16] = rx_byte;
			POS_DST1: dst_d[15:8]  = rx_byte;
			POS_DST2: dst_d[7:0]   = rx_byte;
			default: ;
		endcase
	end

	always_comb begin
		rule_a = (auto_addr_q != '0) && (type_d inside {TYPE_A, TYPE_SETTMP, TYPE_C})
			&& (dst_d == auto_addr_q);
		rule_b = (thermo_addr_q != '0) && (len_d == THERMO_LEN) && (type_d == TYPE_SETTMP)
			&& (dst_d == thermo_addr_q);
	end

	assign q_push = accept && end_of_packet && (pos_q >= POS_MIN_END) && (rule_a || rule_b);
	assign q_data = '{counter: cnt_d, src: src_d, dst: dst_d, rule_a: rule_a, rule_b: rule_b};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_addr_q   <= '0;
			thermo_addr_q <= '0;
			pos_q         <= '0;
			len_q         <= '0;
			cnt_q         <= '0;
			type_q        <= '0;
			src_q         <= '0;
			dst_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_AUTO_ACK_ADDR: auto_addr_q   <= cfg_data;
					REG_THERMO_ADDR:   thermo_addr_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				len_q  <= len_d;
				cnt_q  <= cnt_d;
				type_q <= type_d;
				src_q  <= src_d;
				dst_q  <= dst_d;
				if (end_of_packet)
					pos_q <= '0;
				else if (pos_q != POS_MAX)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/rpa_queue.sv =====
// Short job queue between the capture front end and the ack frame back end.
// Depends on rpa_pkg for the job type and depth.
module rpa_queue import rpa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  ack_job_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     empty,
	output ack_job_t head
);

	ack_job_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/rpa_back.sv =====
// Back end: serializes one or two 12-byte ack frames per queued job.
// Depends on rpa_pkg; reads the head of rpa_queue.
module rpa_back import rpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  ack_job_t          q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] tx_byte,
	output logic              frame_end,
	output logic              run_end
);

	logic [POS_W-1:0] idx_q;
	logic             second_q;
	logic             last_frame, take;

	assign out_valid  = !q_empty;
	assign take       = out_valid && out_ready;
	assign last_frame = !(q_head.rule_a && q_head.rule_b) || second_q;
	assign frame_end  = (idx_q == ACK_LAST);
	assign run_end    = frame_end && last_frame;
	assign q_pop      = take && run_end;

	always_comb begin
		case (idx_q)
			4'd0:    tx_byte = ACK_LEN;
			4'd1:    tx_byte = q_head.counter;
			4'd3:    tx_byte = ACK_TYPE;
			4'd4:    tx_byte = q_head.dst[23:16];
			4'd5:    tx_byte = q_head.dst[15:8];
			4'd6:    tx_byte = q_head.dst[7:0];
			4'd7:    tx_byte = q_head.src[23:16];
			4'd8:    tx_byte = q_head.src[15:8];
			4'd9:    tx_byte = q_head.src[7:0];
			default: tx_byte = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			second_q <= 1'b0;
		end else if (take) begin
			if (frame_end) begin
				idx_q    <= '0;
				second_q <= !last_frame;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/radio_packet_auto_ack.sv =====
// Radio packet auto-ack block, top level.
// Depends on rpa_pkg, rpa_front, rpa_queue and rpa_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries received packet bytes, length
//   byte first, with end_of_packet on the final byte. One byte per cycle is
//   taken while the ack queue has room.
//   Output channel (out_valid/out_ready) carries ack frame bytes: 12 bytes per
//   frame, frame_end on the twelfth, run_end on the last byte caused by a
//   packet. A packet matching both rules gives two frames (24 bytes).
//   cfg_we/cfg_index/cfg_data write the auto-ack address (index 0) and the
//   thermostat address (index 1); write only while the block is idle.
//   A job is queued when the final packet byte is accepted; its first ack
//   byte is valid once it heads the queue. The back end sends one byte per
//   cycle while out_ready is high, from a two-entry job queue. When the
//   receiver stalls, queued jobs hold; once both queue entries are taken,
//   in_ready drops until a job's last byte is sent. Reset clears addresses
//   (acks disabled), the byte position, captured fields and the queue.
module radio_packet_auto_ack import rpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 end_of_packet,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    tx_byte,
	output logic                 frame_end,
	output logic                 run_end
);

	logic     q_push, q_full, q_pop, q_empty;
	ack_job_t q_data, q_head;

	rpa_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.end_of_packet (end_of_packet),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_data)
	);

	rpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	rpa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.tx_byte   (tx_byte),
		.frame_end (frame_end),
		.run_end   (run_end)
	);

endmodule

// ===== dv/rpa_ack_checker.sv =====
// Scoreboard for radio_packet_auto_ack: follows config writes and accepted rx words,
// predicts the ack words and compares each tx word in order. Depends on rpa_pkg.
module rpa_ack_checker import rpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 end_of_packet,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [BYTE_W-1:0]    tx_byte,
	input  logic                 frame_end,
	input  logic                 run_end,
	output int                   fail_count,
	output int                   bytes_due,
	output int                   bytes_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAME_WORDS = 12;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last_of_frame;
		logic              last_of_run;
	} ack_word_t;

	ack_word_t ack_words_due[$];
	ack_word_t want;

	logic [ADDR_W-1:0] own_addr;
	logic [ADDR_W-1:0] thermo_addr;
	logic [POS_W-1:0]  pkt_pos;
	logic [BYTE_W-1:0] pkt_len;
	logic [BYTE_W-1:0] pkt_cnt;
	logic [BYTE_W-1:0] pkt_type;
	logic [ADDR_W-1:0] pkt_src;
	logic [ADDR_W-1:0] pkt_dst;

	task report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t ack checker: %s", $realtime, msg);
	endtask

	// capture one packet word; on the end mark queue zero, one or two ack frames
	task take_rx_word(input logic [BYTE_W-1:0] b, input logic eop);
		int n_frames;
		int k;
		ack_word_t e;
		n_frames = 0;
		case (pkt_pos)
			POS_LEN:  pkt_len = b;
			POS_CNT:  pkt_cnt = b;
			POS_TYPE: pkt_type = b;
			POS_SRC0: pkt_src[23:16] = b;
			POS_SRC1: pkt_src[15:8] = b;
			POS_SRC2: pkt_src[7:0] = b;
			POS_DST0: pkt_dst[23:16] = b;
			POS_DST1: pkt_dst[15:8] = b;
			POS_DST2: pkt_dst[7:0] = b;
			default: ;
		endcase
		if (!eop) begin
			if (pkt_pos != POS_MAX)
				pkt_pos = pkt_pos + 1'b1;
		end else begin
			// fewer than ten words never ack
			if (pkt_pos >= POS_MIN_END) begin
				if (own_addr != '0 && pkt_dst == own_addr &&
				    (pkt_type == TYPE_A || pkt_type == TYPE_SETTMP || pkt_type == TYPE_C))
					n_frames++;
				if (thermo_addr != '0 && pkt_dst == thermo_addr &&
				    pkt_len == THERMO_LEN && pkt_type == TYPE_SETTMP)
					n_frames++;
			end
			pkt_pos = '0;
			for (k = 0; k < FRAME_WORDS * n_frames; k++) begin
				case (k % FRAME_WORDS)
					0:       e.data = ACK_LEN;
					1:       e.data = pkt_cnt;
					3:       e.data = ACK_TYPE;
					4:       e.data = pkt_dst[23:16];
					5:       e.data = pkt_dst[15:8];
					6:       e.data = pkt_dst[7:0];
					7:       e.data = pkt_src[23:16];
					8:       e.data = pkt_src[15:8];
					9:       e.data = pkt_src[7:0];
					default: e.data = '0;
				endcase
				e.last_of_frame = (k % FRAME_WORDS == FRAME_WORDS - 1);
				e.last_of_run = (k == FRAME_WORDS * n_frames - 1);
				ack_words_due.push_back(e);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_words_due.delete();
			own_addr = '0;
			thermo_addr = '0;
			pkt_pos = '0;
			pkt_len = '0;
			pkt_cnt = '0;
			pkt_type = '0;
			pkt_src = '0;
			pkt_dst = '0;
			fail_count = 0;
			bytes_due = 0;
			bytes_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (ack_words_due.size() == 0) begin
					report_mismatch($sformatf("tx word %h with nothing expected", tx_byte));
				end else begin
					want = ack_words_due.pop_front();
					if (tx_byte !== want.data)
						report_mismatch($sformatf("tx_byte %h, expected %h",
							tx_byte, want.data));
					if (frame_end !== want.last_of_frame)
						report_mismatch($sformatf("frame_end %b, expected %b",
							frame_end, want.last_of_frame));
					if (run_end !== want.last_of_run)
						report_mismatch($sformatf("run_end %b, expected %b",
							run_end, want.last_of_run));
					bytes_checked++;
				end
			end
			if (in_valid && in_ready)
				take_rx_word(rx_byte, end_of_packet);
			if (cfg_we) begin
				case (cfg_index)
					REG_AUTO_ACK_ADDR: own_addr = cfg_data;
					REG_THERMO_ADDR:   thermo_addr = cfg_data;
					default: ;
				endcase
			end
			bytes_due = ack_words_due.size();
		end
	end

endmodule

// ===== dv/tb_radio_packet_auto_ack.sv =====
// Top testbench for radio_packet_auto_ack: clock, reset, packet and config stimulus,
// random stalls on both channels, watchdog and verdict. Depends on rpa_pkg, rpa_ack_checker.
module tb_radio_packet_auto_ack;
	timeunit 1ns;
	timeprecision 1ps;
	import rpa_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int PHASE_WORDS    = 35;
	localparam int SETTLE_CYCLES  = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_AUTO_ACK_ADDR;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte = '0;
	logic                 end_of_packet = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [BYTE_W-1:0]    tx_byte;
	logic                 frame_end;
	logic                 run_end;

	int fail_count;
	int bytes_due;
	int bytes_checked;

	logic [ADDR_W-1:0] cur_own = '0;
	logic [ADDR_W-1:0] cur_thermo = '0;
	bit steady = 1'b0;
	bit hold_req = 1'b0;
	int held_cycles = 0;
	int words_sent = 0;
	int packets_sent = 0;
	int settings_used = 0;
	int idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	radio_packet_auto_ack i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.end_of_packet (end_of_packet),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_byte       (tx_byte),
		.frame_end     (frame_end),
		.run_end       (run_end)
	);

	rpa_ack_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.end_of_packet (end_of_packet),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.tx_byte       (tx_byte),
		.frame_end     (frame_end),
		.run_end       (run_end),
		.fail_count    (fail_count),
		.bytes_due     (bytes_due),
		.bytes_checked (bytes_checked)
	);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ack receiver: random stalls per word, one long hold-off on request
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				held_cycles += HOLD_CYCLES;
			end
			gap = steady ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			@(negedge clk);
		end
	end

	task set_addresses(input logic [ADDR_W-1:0] own, input logic [ADDR_W-1:0] thermo);
		cfg_we <= 1'b1;
		cfg_index <= REG_AUTO_ACK_ADDR;
		cfg_data <= own;
		@(negedge clk);
		cfg_index <= REG_THERMO_ADDR;
		cfg_data <= thermo;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_own = own;
		cur_thermo = thermo;
		settings_used++;
	endtask

	task settle_input();
		in_valid <= 1'b0;
		while (bytes_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task send_packet(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] cnt,
	                 input logic [BYTE_W-1:0] typ, input logic [ADDR_W-1:0] src,
	                 input logic [ADDR_W-1:0] dst, input int n_words);
		int i;
		int gap;
		logic [BYTE_W-1:0] b;
		for (i = 0; i < n_words; i++) begin
			case (i)
				0:       b = len;
				1:       b = cnt;
				3:       b = typ;
				4:       b = src[23:16];
				5:       b = src[15:8];
				6:       b = src[7:0];
				7:       b = dst[23:16];
				8:       b = dst[15:8];
				9:       b = dst[7:0];
				default: b = BYTE_W'($urandom);
			endcase
			gap = steady ? 0 : $urandom_range(0, 4);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			in_valid <= 1'b1;
			rx_byte <= b;
			end_of_packet <= (i == n_words - 1);
			@(posedge clk);
			while (!in_ready)
				@(posedge clk);
			@(negedge clk);
			words_sent++;
		end
		packets_sent++;
	endtask

	// mostly packets aimed at one of the addresses, the rest noise of 1 to 20 words
	task random_packet(input bit force_ack);
		logic [BYTE_W-1:0] len;
		logic [BYTE_W-1:0] typ;
		logic [ADDR_W-1:0] dst;
		int n_words;
		int pick;
		if (force_ack) begin
			len = THERMO_LEN;
			typ = TYPE_SETTMP;
			dst = cur_own;
			n_words = 11;
		end else if ($urandom_range(0, 3) != 0) begin
			pick = $urandom_range(0, 5);
			dst = (pick < 3) ? cur_own : (pick < 5) ? cur_thermo : ADDR_W'($urandom);
			case ($urandom_range(0, 4))
				0:       typ = TYPE_A;
				1, 2:    typ = TYPE_SETTMP;
				3:       typ = TYPE_C;
				default: typ = BYTE_W'($urandom);
			endcase
			len = ($urandom_range(0, 3) != 0) ? THERMO_LEN : BYTE_W'($urandom);
			n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20)
			                                      : $urandom_range(10, 12);
		end else begin
			len = BYTE_W'($urandom);
			typ = $urandom_range(0, 1) ? TYPE_SETTMP : BYTE_W'($urandom);
			dst = $urandom_range(0, 1) ? cur_own : ADDR_W'($urandom);
			n_words = $urandom_range(1, 20);
		end
		send_packet(len, BYTE_W'($urandom), typ, ADDR_W'($urandom), dst, n_words);
	endtask

	initial begin
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] t;
		int p;
		int phase_start;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// both rules on one address, short packet, ten-word packet, lone end mark
		set_addresses(24'hA1B2C3, 24'hA1B2C3);
		send_packet(THERMO_LEN, 8'h5A, TYPE_SETTMP, 24'h123456, 24'hA1B2C3, 11);
		send_packet(8'h03, 8'h00, TYPE_A, 24'h000000, 24'hA1B2C3, 4);
		send_packet(8'hFF, 8'hFF, TYPE_A, 24'hFFFFFF, 24'hA1B2C3, 10);
		send_packet(8'h00, 8'h00, 8'h00, 24'h000000, 24'h000000, 1);

		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin a = '0; t = '0; end
				1: begin a = '1; t = '1; end
				2: begin a = ADDR_W'($urandom_range(1, 24'hFFFFFF)); t = '0; end
				3: begin a = '0; t = ADDR_W'($urandom_range(1, 24'hFFFFFF)); end
				4: begin
					a = ADDR_W'($urandom_range(1, 24'hFFFFFF));
					t = ADDR_W'($urandom_range(1, 24'hFFFFFF));
				end
				default: begin a = ADDR_W'($urandom_range(1, 24'hFFFFFF)); t = a; end
			endcase
			settle_input();
			set_addresses(a, t);
			steady = (p == 1 || p == 4);
			phase_start = words_sent;
			while (words_sent - phase_start < PHASE_WORDS)
				random_packet(1'b0);
		end

		// receiver holds off while double-ack packets keep coming
		settle_input();
		a = ADDR_W'($urandom_range(1, 24'hFFFFFF));
		set_addresses(a, a);
		steady = 1'b1;
		hold_req = 1'b1;
		repeat (4) random_packet(1'b1);
		steady = 1'b0;

		settle_input();
		$display("tb: %0d packets (%0d words) under %0d address settings, %0d ack words checked",
			packets_sent, words_sent, settings_used, bytes_checked);
		$display("tb: receiver hold-off of %0d cycles against a busy sender", held_cycles);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
